/* src/sapb_pkg.sv */
package sapb_pkg;

  typedef enum logic [1:0] {
    FMT_565 = 2'd0,
    FMT_555 = 2'd1,
    FMT_444 = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    MODE_CONST       = 2'd0,
    MODE_CONST_ALPHA = 2'd1,
    MODE_VARY        = 2'd2
  } mode_e;

  localparam logic [1:0] REG_FORMAT    = 2'd0;
  localparam logic [1:0] REG_MODE      = 2'd1;
  localparam logic [1:0] REG_FILL      = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned IN_W   = 56;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [1:0]  mode;
    logic [31:0] fill;
    logic [7:0]  thr;
  } cfg_t;

  // after decode: alpha known, destination widened to 8-bit channels
  typedef struct packed {
    logic [1:0]  fmt;
    logic        wr;
    logic        plain;
    logic [7:0]  alpha;
    logic [23:0] src;
    logic [23:0] dst_rgb;
    logic [15:0] dst;
  } s1_t;

  // after channel multiply: (a+1)*(s-d) per channel, red in lane 2
  typedef struct packed {
    logic [1:0]       fmt;
    logic             wr;
    logic             plain;
    logic [23:0]      src;
    logic [23:0]      dst_rgb;
    logic [15:0]      dst;
    logic [2:0][17:0] prod;
  } s2_t;

endpackage

/* src/sapb_cfg.sv */
module sapb_cfg
  import sapb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic [1:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FORMAT:    cfg_d.fmt  = pwdata[1:0];
        REG_MODE:      cfg_d.mode = pwdata[1:0];
        REG_FILL:      cfg_d.fill = pwdata;
        REG_THRESHOLD: cfg_d.thr  = pwdata[7:0];
        default:       cfg_d      = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_FORMAT:    prdata = {30'd0, cfg_q.fmt};
      REG_MODE:      prdata = {30'd0, cfg_q.mode};
      REG_FILL:      prdata = cfg_q.fill;
      REG_THRESHOLD: prdata = {24'd0, cfg_q.thr};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/sapb_setup.sv */
module sapb_setup
  import sapb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] source_color_i,
  input  logic [15:0] dest_pixel_i,
  input  logic [7:0]  coverage_i,
  output logic        valid_o,
  input  logic        ready_i,
  output s1_t         data_o
);

  logic        valid_q;
  s1_t         data_q, data_d;
  logic [7:0]  src_a;
  logic [31:0] colour;
  logic [16:0] a_prod;
  logic [7:0]  a_scaled;
  logic        fmt_ok, mode_ok, thr_ok, pass;

  always_comb begin
    colour   = (cfg_i.mode == MODE_VARY) ? source_color_i : cfg_i.fill;
    src_a    = colour[31:24];
    a_prod   = ({1'b0, src_a} + 9'd1) * coverage_i;
    a_scaled = a_prod[15:8];
    fmt_ok   = (cfg_i.fmt == FMT_565) || (cfg_i.fmt == FMT_555) || (cfg_i.fmt == FMT_444);
    mode_ok  = (cfg_i.mode == MODE_CONST) || (cfg_i.mode == MODE_CONST_ALPHA) ||
               (cfg_i.mode == MODE_VARY);
    thr_ok   = (cfg_i.fmt == FMT_565) || (coverage_i >= cfg_i.thr);
    pass     = fmt_ok && mode_ok && thr_ok;

    data_d.fmt = cfg_i.fmt;
    data_d.src = colour[23:0];
    data_d.dst = dest_pixel_i;
    unique case (cfg_i.mode)
      MODE_CONST: begin
        data_d.wr    = pass;
        data_d.plain = (coverage_i == 8'hFF);
        data_d.alpha = coverage_i;
      end
      MODE_CONST_ALPHA: begin
        data_d.wr    = pass;
        data_d.plain = 1'b0;
        data_d.alpha = a_scaled;
      end
      MODE_VARY: begin
        data_d.wr    = pass && (src_a != 8'h00);
        data_d.plain = (coverage_i == 8'hFF) && (src_a == 8'hFF);
        data_d.alpha = a_scaled;
      end
      default: begin
        data_d.wr    = 1'b0;
        data_d.plain = 1'b0;
        data_d.alpha = a_scaled;
      end
    endcase

    unique case (cfg_i.fmt)
      FMT_565: data_d.dst_rgb = {dest_pixel_i[15:11], 3'b000, dest_pixel_i[10:5], 2'b00,
                                 dest_pixel_i[4:0], 3'b000};
      FMT_555: data_d.dst_rgb = {dest_pixel_i[14:10], 3'b000, dest_pixel_i[9:5], 3'b000,
                                 dest_pixel_i[4:0], 3'b000};
      default: data_d.dst_rgb = {dest_pixel_i[11:8], 4'h0, dest_pixel_i[7:4], 4'h0,
                                 dest_pixel_i[3:0], 4'h0};
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* src/sapb_mul.sv */
module sapb_mul
  import sapb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  s1_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s2_t  data_o
);

  logic        valid_q;
  s2_t         data_q, data_d;
  logic [8:0]  a_inc;
  logic signed [17:0] a_s;
  logic signed [8:0]  diff [3];
  logic signed [17:0] diff_s [3];

  assign a_inc = {1'b0, data_i.alpha} + 9'd1;
  assign a_s   = {9'd0, a_inc};

  always_comb begin
    data_d.fmt     = data_i.fmt;
    data_d.wr      = data_i.wr;
    data_d.plain   = data_i.plain;
    data_d.src     = data_i.src;
    data_d.dst_rgb = data_i.dst_rgb;
    data_d.dst     = data_i.dst;
    for (int i = 0; i < 3; i++) begin
      diff[i]        = $signed({1'b0, data_i.src[8*i +: 8]}) -
                       $signed({1'b0, data_i.dst_rgb[8*i +: 8]});
      diff_s[i]      = {{9{diff[i][8]}}, diff[i]};
      data_d.prod[i] = a_s * diff_s[i];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* src/sapb_pack.sv */
module sapb_pack
  import sapb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  s2_t         data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [15:0] new_pixel_o,
  output logic        write_enable_o
);

  logic        valid_q;
  logic [15:0] pix_q, pix_d;
  logic        we_q;
  logic [23:0] rgb;
  logic [7:0]  r, g, b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // arithmetic top bits give the floor of the shift
      rgb[8*i +: 8] = data_i.prod[i][15:8] + data_i.dst_rgb[8*i +: 8];
    end
    if (data_i.plain) begin
      rgb = data_i.src;
    end
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    unique case (data_i.fmt)
      FMT_565: pix_d = {r[7:3], g[7:2], b[7:3]};
      FMT_555: pix_d = {1'b0, r[7:3], g[7:3], b[7:3]};
      default: pix_d = {4'h0, r[7:4], g[7:4], b[7:4]};
    endcase
    if (!data_i.wr) begin
      pix_d = data_i.dst;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= pix_d;
      we_q  <= data_i.wr;
    end
  end

  assign valid_o        = valid_q;
  assign new_pixel_o    = pix_q;
  assign write_enable_o = we_q;

endmodule

/* src/span_pixel_alpha_blender.sv */
// Span pixel alpha blender: ARGB 8888 colour over a 565, 555 or 444 pixel.
// Input stream (s_axis): one item per pixel, tdata carries source colour,
// destination pixel and coverage. Output stream (m_axis): tdata carries the
// new pixel, tuser the write flag; every input item gives exactly one result.
// The APB port sets format, fill mode, fill colour and coverage threshold at
// byte addresses 0, 4, 8 and 12; write it only while the pipe is empty.
// The pipe has three register stages from input handshake to output valid:
// decode with the alpha multiply, the per-channel multiply, then add and
// repack, each closed by a register stage. One item per cycle is sustained
// while the receiver keeps tready high.
// When the receiver stalls, the output register holds its item and the stages
// behind it go on filling; s_axis_tready drops only once every stage is full.
// Reset clears all valid bits and sets the configuration registers to zero.
module span_pixel_alpha_blender
  import sapb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // source_color, dest_pixel, coverage
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // new_pixel
  output logic              m_axis_tuser    // write_enable
);

  cfg_t cfg;
  logic v1, r1, v2, r2;
  s1_t  d1;
  s2_t  d2;

  assign pready = 1'b1;

  sapb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  sapb_setup u_setup (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .source_color_i (s_axis_tdata[31:0]),
    .dest_pixel_i   (s_axis_tdata[47:32]),
    .coverage_i     (s_axis_tdata[55:48]),
    .valid_o        (v1),
    .ready_i        (r1),
    .data_o         (d1)
  );

  sapb_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r1),
    .data_i  (d1),
    .valid_o (v2),
    .ready_i (r2),
    .data_o  (d2)
  );

  sapb_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (v2),
    .ready_o        (r2),
    .data_i         (d2),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .new_pixel_o    (m_axis_tdata),
    .write_enable_o (m_axis_tuser)
  );

endmodule

/* src/sapb_checker.sv */
module sapb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("item not delivered after three cycles");

endmodule

bind span_pixel_alpha_blender sapb_checker u_sapb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* dv/tb_span_pixel_alpha_blender.sv */
`timescale 1ns / 100ps

module tb_span_pixel_alpha_blender;
  import sapb_pkg::*;

  localparam logic [1:0] FMT_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct packed {
    logic [15:0] pix;
    logic        wr;
  } pixel_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;  // source_color, dest_pixel, coverage
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;       // new_pixel
  logic              m_axis_tuser;       // write_enable

  cfg_t          model_cfg = '0;
  pixel_result_t pending_pixels[$];
  pixel_result_t head;
  int unsigned   errors = 0;
  int unsigned   quiet_cycles = 0;
  bit            tx_jitter = 1'b1;
  bit            rx_jitter = 1'b1;

  span_pixel_alpha_blender u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] scale_alpha(logic [7:0] a, logic [7:0] cov);
    int p;
    p = (int'(a) + 1) * int'(cov);
    return p[15:8];
  endfunction

  // d + floor((a+1)*(s-d)/256)
  function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] s, logic [7:0] d);
    int p;
    int r;
    p = (int'(a) + 1) * (int'(s) - int'(d));
    r = int'(d) + (p >>> 8);
    return r[7:0];
  endfunction

  function automatic logic [15:0] pack_rgb(logic [1:0] fmt, logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b);
    case (fmt)
      FMT_565: return {r[7:3], g[7:2], b[7:3]};
      FMT_555: return {1'b0, r[7:3], g[7:3], b[7:3]};
      default: return {4'b0, r[7:4], g[7:4], b[7:4]};
    endcase
  endfunction

  function automatic logic [23:0] widen_dest(logic [1:0] fmt, logic [15:0] d);
    case (fmt)
      FMT_565: return {d[15:11], 3'b0, d[10:5], 2'b0, d[4:0], 3'b0};
      FMT_555: return {d[14:10], 3'b0, d[9:5], 3'b0, d[4:0], 3'b0};
      default: return {d[11:8], 4'b0, d[7:4], 4'b0, d[3:0], 4'b0};
    endcase
  endfunction

  function automatic pixel_result_t blend_pixel(cfg_t c, logic [31:0] src, logic [15:0] dst,
                                                logic [7:0] cov);
    pixel_result_t res;
    logic [31:0]   colour;
    logic [23:0]   d;
    logic [7:0]    alpha;
    logic          plain;
    bit            fmt_ok;
    bit            mode_ok;
    res.pix = dst;
    res.wr  = 1'b0;
    fmt_ok  = (c.fmt == FMT_565) || (c.fmt == FMT_555) || (c.fmt == FMT_444);
    mode_ok = (c.mode == MODE_CONST) || (c.mode == MODE_CONST_ALPHA) || (c.mode == MODE_VARY);
    if (!fmt_ok || !mode_ok || (c.fmt != FMT_565 && cov < c.thr))
      return res;
    case (c.mode)
      MODE_CONST: begin
        colour = c.fill;
        plain  = (cov == 8'hFF);
        alpha  = cov;
      end
      MODE_CONST_ALPHA: begin
        colour = c.fill;
        plain  = 1'b0;
        alpha  = scale_alpha(c.fill[31:24], cov);
      end
      default: begin
        colour = src;
        if (src[31:24] == 8'h00)
          return res;
        plain = (cov == 8'hFF) && (src[31:24] == 8'hFF);
        alpha = scale_alpha(src[31:24], cov);
      end
    endcase
    d      = widen_dest(c.fmt, dst);
    res.wr = 1'b1;
    if (plain)
      res.pix = pack_rgb(c.fmt, colour[23:16], colour[15:8], colour[7:0]);
    else
      res.pix = pack_rgb(c.fmt, mix_channel(alpha, colour[23:16], d[23:16]),
                         mix_channel(alpha, colour[15:8], d[15:8]),
                         mix_channel(alpha, colour[7:0], d[7:0]));
    return res;
  endfunction

  // ---------------------------------------------------------------- receiver, checker, watchdog
  always @(posedge clk_i)
    m_axis_tready <= !(rx_jitter && ($urandom_range(99) < 17));

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: pix %h we %b", m_axis_tdata, m_axis_tuser);
      end else begin
        head = pending_pixels.pop_front();
        if (head.pix !== m_axis_tdata || head.wr !== m_axis_tuser) begin
          errors++;
          if (errors <= 10)
            $display("item mismatch: expected pix %h we %b, got pix %h we %b",
                     head.pix, head.wr, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_pixel(input logic [31:0] src, input logic [15:0] dst,
                            input logic [7:0] cov);
    while (tx_jitter && ($urandom_range(99) < 17)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cov, dst, src};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pixels.push_back(blend_pixel(model_cfg, src, dst, cov));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FORMAT: model_cfg.fmt  = value[1:0];
      REG_MODE:   model_cfg.mode = value[1:0];
      REG_FILL:   model_cfg.fill = value;
      default:    model_cfg.thr  = value[7:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [1:0] fmt, input logic [1:0] mode,
                            input logic [31:0] fill, input logic [7:0] thr);
    wait_drained();
    apb_write(REG_FORMAT, {30'b0, fmt});
    apb_write(REG_MODE, {30'b0, mode});
    apb_write(REG_FILL, fill);
    apb_write(REG_THRESHOLD, {24'b0, thr});
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_values();
    send_pixel(32'h0000_0000, 16'h0000, 8'h00);
    send_pixel(32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_constant_fill();
    set_config(FMT_565, MODE_CONST, 32'h00FF_8040, 8'h00);
    send_pixel(32'h0000_0000, 16'h1234, 8'hFF);
    send_pixel(32'hFFFF_FFFF, 16'hFFFF, 8'h00);
    send_pixel(32'h0000_0000, 16'hFFFF, 8'hFE);
    set_config(FMT_555, MODE_CONST, 32'h00FF_8040, 8'h80);
    send_pixel(32'h0000_0000, 16'hABCD, 8'h7F);  // below threshold
    send_pixel(32'h0000_0000, 16'hABCD, 8'h80);
  endtask

  task automatic test_constant_alpha();
    set_config(FMT_444, MODE_CONST_ALPHA, 32'h0012_3456, 8'h00);
    send_pixel(32'h0000_0000, 16'hFFFF, 8'hFF);  // zero alpha, unused bits cleared
    set_config(FMT_444, MODE_CONST_ALPHA, 32'hFF89_ABCD, 8'h00);
    send_pixel(32'h0000_0000, 16'h0000, 8'hFF);
    send_pixel(32'h0000_0000, 16'hFFFF, 8'h01);
  endtask

  task automatic test_varying_source();
    set_config(FMT_555, MODE_VARY, 32'h0000_0000, 8'h00);
    send_pixel(32'h00FF_FFFF, 16'h5555, 8'hFF);  // transparent source
    send_pixel(32'hFFAB_CDEF, 16'h0000, 8'hFF);  // opaque copy
    send_pixel(32'hFFAB_CDEF, 16'hFFFF, 8'hFE);
    send_pixel(32'h01FF_FFFF, 16'h0000, 8'hFF);
    send_pixel(32'h80FF_FFFF, 16'hFFFF, 8'h00);
    set_config(FMT_565, MODE_VARY, 32'hFFFF_FFFF, 8'hFF);
    send_pixel(32'h7F12_3456, 16'h8000, 8'h00);  // threshold ignored for 565
  endtask

  task automatic test_unused_codes();
    set_config(FMT_UNUSED, MODE_CONST, 32'hFFFF_FFFF, 8'h00);
    send_pixel(32'hFFFF_FFFF, 16'h1357, 8'hFF);
    set_config(FMT_565, MODE_UNUSED, 32'hFFFF_FFFF, 8'h00);
    send_pixel(32'hFFFF_FFFF, 16'h2468, 8'hFF);
  endtask

  task automatic random_pixel(input logic [7:0] thr);
    logic [31:0] src;
    logic [7:0]  cov;
    int unsigned pick;
    src  = $urandom();
    pick = $urandom_range(99);
    if (pick < 20)
      src[31:24] = 8'h00;
    else if (pick < 40)
      src[31:24] = 8'hFF;
    pick = $urandom_range(99);
    if (pick < 15)
      cov = 8'h00;
    else if (pick < 30)
      cov = 8'hFF;
    else if (pick < 40)
      cov = thr - 8'($urandom_range(1));
    else
      cov = 8'($urandom_range(255));
    send_pixel(src, 16'($urandom_range(16'hFFFF)), cov);
  endtask

  task automatic test_random_phases();
    logic [1:0]  fmt;
    logic [1:0]  mode;
    logic [31:0] fill;
    logic [7:0]  thr;
    for (int phase = 0; phase < 10; phase++) begin
      fill = $urandom();
      thr  = 8'($urandom_range(255));
      fmt  = ($urandom_range(11) == 0) ? FMT_UNUSED : 2'($urandom_range(2));
      mode = ($urandom_range(11) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
      case (phase)
        0: begin fmt = FMT_565; mode = MODE_CONST;       fill = 32'hFFFF_FFFF; thr = 8'hFF; end
        1: begin fmt = FMT_444; mode = MODE_VARY;        fill = 32'h0000_0000; thr = 8'h00; end
        2: begin fmt = FMT_555; mode = MODE_CONST_ALPHA; fill = 32'hFF00_0000; thr = 8'hFF; end
        3: begin fmt = FMT_565; mode = MODE_VARY; end
        default: ;
      endcase
      if ($urandom_range(3) == 0)
        fill[31:24] = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
      set_config(fmt, mode, fill, thr);
      tx_jitter = (phase != 3);
      rx_jitter = (phase != 3);
      for (int n = 0; n < 70; n++) begin
        if (phase == 5 && n == 35)
          wait_drained();  // sender holds off until the pipe has emptied
        random_pixel(thr);
      end
    end
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_constant_fill();
    test_constant_alpha();
    test_varying_source();
    test_unused_codes();
    test_random_phases();
    wait_drained();
    if (errors == 0 && pending_pixels.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
